// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Sizes, request and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH   = 8;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 4;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

	// One access to the slot memory.
	typedef struct packed {
		logic             we;
		logic             re;
		logic [IDX_W-1:0] addr;
	} deq_access_t;

	// Everything about a result beat except the popped word.
	typedef struct packed {
		logic               pop_ok;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
	} deq_meta_t;

	// Modular add of a slot index and an offset below DEPTH.
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W:0] a,
		input logic [IDX_W:0] b);
		logic [IDX_W+1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+2)'(DEPTH)) begin
			s = s - (IDX_W+2)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/core/deq_store.sv =====
// ----------------------------------------------------------------------------
// deq_store: slot memory of the double-ended queue
// One port, one access per cycle, registered read data that holds when idle.
// ----------------------------------------------------------------------------
module deq_store
	import deq_pkg::*;
(
	input  logic              clk,
	input  deq_access_t       acc,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (acc.we) begin
			mem[acc.addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (acc.re) begin
			rdata_q <= mem[acc.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: head and fill bookkeeping of the double-ended queue
// Decodes a request, picks the slot to touch and updates head and count.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [REQ_W-1:0] req_type,
	output deq_access_t      acc,
	output deq_meta_t        meta
);

	logic [IDX_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  head_d;
	logic [FILL_W-1:0] fill_d;
	logic              is_push;
	logic              full_now;
	logic              empty_now;
	logic              ok;

	assign is_push   = (req_type == REQ_PUSH_BACK) || (req_type == REQ_PUSH_FRONT);
	assign full_now  = (fill_q == FILL_W'(DEPTH));
	assign empty_now = (fill_q == '0);
	assign ok        = is_push ? !full_now : !empty_now;

	always_comb begin
		head_d   = head_q;
		fill_d   = fill_q;
		acc.we   = 1'b0;
		acc.re   = 1'b0;
		acc.addr = head_q;
		case (req_type)
			REQ_PUSH_BACK: begin
				acc.addr = wrap_add((IDX_W+1)'(head_q), (IDX_W+1)'(fill_q));
				acc.we   = take && ok;
				fill_d   = fill_q + FILL_W'(1);
			end
			REQ_PUSH_FRONT: begin
				acc.addr = wrap_add((IDX_W+1)'(head_q), (IDX_W+1)'(DEPTH - 1));
				acc.we   = take && ok;
				head_d   = acc.addr;
				fill_d   = fill_q + FILL_W'(1);
			end
			REQ_POP_BACK: begin
				acc.addr = wrap_add((IDX_W+1)'(head_q),
					(IDX_W+1)'(fill_q - FILL_W'(1)));
				acc.re   = take && ok;
				fill_d   = fill_q - FILL_W'(1);
			end
			REQ_POP_FRONT: begin
				acc.addr = head_q;
				acc.re   = take && ok;
				head_d   = wrap_add((IDX_W+1)'(head_q), (IDX_W+1)'(1));
				fill_d   = fill_q - FILL_W'(1);
			end
			default: begin
				acc.addr = head_q;
			end
		endcase
		if (!ok) begin
			head_d = head_q;
			fill_d = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (take) begin
			head_q <= head_d;
			fill_q <= fill_d;
		end
	end

	always_comb begin
		meta.pop_ok   = ok && !is_push;
		meta.status   = ok ? ST_DONE : (is_push ? ST_OVERFLOW : ST_UNDERFLOW);
		meta.count    = COUNT_W'(fill_d);
		meta.is_empty = (fill_d == '0);
		meta.is_full  = (fill_d == FILL_W'(DEPTH));
	end

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of signed words
// Circular buffer with push and pop at both ends, one result beat per request.
// ----------------------------------------------------------------------------
// The queue keeps up to DEPTH signed 32-bit words in a single-port slot memory
// described by a head index and a fill count. Each input beat is a request:
// push back, push front, pop back or pop front. Each request yields exactly
// one result beat carrying the popped word (zero unless a pop succeeded), a
// status (done, overflow on a push into a full queue, underflow on a pop from
// an empty queue), the count after the request, and empty and full flags.
// A failed request changes nothing. The block takes one request per clock
// cycle when the output side keeps up; an accepted request passes through the
// memory read, then the output register. Head and count are updated at the
// accept edge, so the next request sees them at once, and since each request
// makes at most one memory access there is never a read and a write in the
// same cycle. When the output register is held, the read stage holds too, and
// input ready drops once the read stage holds a request.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [STAT_W-1:0]        status,
	output logic [COUNT_W-1:0]       count,
	output logic                     is_empty,
	output logic                     is_full
);

	deq_access_t       acc;
	deq_meta_t         meta;
	logic [DATA_W-1:0] rdata;
	logic              take;
	logic              advance;

	// Read stage: the request whose memory read is in flight.
	logic              v_s1;
	deq_meta_t         meta_s1;

	// Output register.
	logic              out_v_q;
	deq_meta_t         out_meta_q;
	logic [DATA_W-1:0] out_data_q;

	// The read stage moves on when the output register is free or drained.
	assign advance  = !out_v_q || out_ready;
	assign in_ready = !v_s1 || advance;
	assign take     = in_valid && in_ready;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req_type (req_type),
		.acc      (acc),
		.meta     (meta)
	);

	// The memory read register only loads on an accepted pop, so it holds
	// its word while the read stage is stalled.
	deq_store u_store (
		.clk   (clk),
		.acc   (acc),
		.wdata (push_value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			meta_s1 <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			out_meta_q <= meta_s1;
			out_data_q <= meta_s1.pop_ok ? rdata : '0;
		end
	end

	assign out_valid = out_v_q;
	assign pop_value = out_data_q;
	assign status    = out_meta_q.status;
	assign count     = out_meta_q.count;
	assign is_empty  = out_meta_q.is_empty;
	assign is_full   = out_meta_q.is_full;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue_unit
// Drives push and pop requests at both ends of the queue and checks every
// result beat against table answers or a cycle-free model of the circular buffer.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-picked requests. It covers pops
// from the empty queue, the extreme words at both ends, filling the queue
// with head wrap, pushes into a full queue and a full drain. Rows whose
// answer is obvious carry it in the table. All other rows, and every random
// request after them, are checked against the model kept in this file.
// The random part is a biased walk between pushes and pops, so the queue
// swings between empty and full many times. It runs through several
// handshake phases: no idling, a mostly idle sender, a mostly stalled
// receiver, and both at once. One long receiver hold-off fills the pipe and
// stalls the input, and the sender waits for a full drain between phases.
// A watchdog ends the run if no beat moves on either side for too long.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted beat before the run is declared hung. The
	// longest legitimate quiet stretch is the receiver hold-off below.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_PRINTS     = 40;

	// One result beat, field by field, at the widths of the ports.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [STAT_W-1:0]        stat;
		logic [COUNT_W-1:0]       cnt;
		logic                     empty;
		logic                     full;
	} deq_result_t;

	// One row of the directed table. When typed is set, want is the result
	// written down by hand; otherwise the model supplies it.
	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [DATA_W-1:0] word;
		logic              typed;
		deq_result_t       want;
	} stim_row_t;

	localparam int N_DIRECTED = 26;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// Pops from the queue right after reset: underflow, nothing changes.
		// The word offered with a pop must be ignored.
		'{REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'sh0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}},
		'{REQ_POP_FRONT,  32'h5A5A_5A5A, 1'b1, '{32'sh0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}},
		// Largest and smallest words, one at each end, each popped from the
		// same end it went in at.
		'{REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'sh0, ST_DONE, 4'd1, 1'b0, 1'b0}},
		'{REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'sh0, ST_DONE, 4'd2, 1'b0, 1'b0}},
		'{REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1,
			'{32'sh7FFF_FFFF, ST_DONE, 4'd1, 1'b0, 1'b0}},
		'{REQ_POP_FRONT,  32'h0000_0000, 1'b1,
			'{32'sh8000_0000, ST_DONE, 4'd0, 1'b1, 1'b0}},
		'{REQ_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'sh0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}},
		// Fill from both ends so the head wraps below slot zero.
		'{REQ_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h8000_0001, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h7FFF_FFFE, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
		// Pushes into the full queue at either end are refused.
		'{REQ_PUSH_BACK,  32'h1234_5678, 1'b1, '{32'sh0, ST_OVERFLOW, 4'd8, 1'b0, 1'b1}},
		'{REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'sh0, ST_OVERFLOW, 4'd8, 1'b0, 1'b1}},
		// Drain from alternating ends, then one pop too many.
		'{REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
		'{REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
		'{REQ_POP_BACK,   32'h0000_0000, 1'b1, '{32'sh0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0}}
	};

	// Every input has a known value from time zero.
	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic [REQ_W-1:0]         req_type   = REQ_PUSH_BACK;
	logic signed [DATA_W-1:0] push_value = '0;
	logic                     out_ready  = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic signed [DATA_W-1:0] pop_value;
	logic [STAT_W-1:0]        status;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;
	logic                     is_full;

	// Bench-side companions of the request payload. They change together with
	// the payload, so the monitor sees the hand-written answer of a table row
	// at the same edge as the request itself.
	logic        row_typed = 1'b0;
	deq_result_t row_want  = '0;

	// Model of the queue contents, kept in step with accepted requests.
	logic signed [DATA_W-1:0] model_slots [DEPTH];
	int                       model_head;
	int                       model_fill;

	// Results owed by the block, oldest first.
	deq_result_t awaited_results [$];

	// Handshake shaping, set by the stimulus process between phases.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;

	int mismatches    = 0;
	int requests_seen = 0;
	int pushes_seen   = 0;
	int pops_seen     = 0;
	int results_seen  = 0;
	int overflows     = 0;
	int underflows    = 0;
	int full_results  = 0;

	double_ended_queue_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pop_value  (pop_value),
		.status     (status),
		.count      (count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	always #2 clk = ~clk;

	// Applies one request to the queue model and returns the result beat the
	// block should give for it. Indices wrap modulo DEPTH; a refused request
	// leaves head and fill untouched.
	function automatic deq_result_t deque_apply(logic [REQ_W-1:0] req,
		logic signed [DATA_W-1:0] word);
		deq_result_t r;
		int          slot;
		r       = '0;
		r.stat  = ST_DONE;
		case (req)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (model_fill >= DEPTH) begin
					r.stat = ST_OVERFLOW;
				end else if (req == REQ_PUSH_BACK) begin
					slot = (model_head + model_fill) % DEPTH;
					model_slots[slot] = word;
					model_fill++;
				end else begin
					model_head = (model_head + DEPTH - 1) % DEPTH;
					model_slots[model_head] = word;
					model_fill++;
				end
			end
			default: begin
				if (model_fill == 0) begin
					r.stat = ST_UNDERFLOW;
				end else if (req == REQ_POP_BACK) begin
					slot    = (model_head + model_fill - 1) % DEPTH;
					r.value = model_slots[slot];
					model_fill--;
				end else begin
					r.value    = model_slots[model_head];
					model_head = (model_head + 1) % DEPTH;
					model_fill--;
				end
			end
		endcase
		r.cnt   = COUNT_W'(model_fill);
		r.empty = (model_fill == 0);
		r.full  = (model_fill == DEPTH);
		return r;
	endfunction

	// Prints one line per mismatch, up to a cap, and counts all of them.
	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
		logic [DATA_W-1:0] want);
		if (mismatches < MAX_PRINTS) begin
			$display("%0t: mismatch on %s after %0d results: got %h, expected %h",
				$realtime, what, results_seen, got, want);
		end
		mismatches++;
	endtask

	// Monitor. It samples at the rising edge, where every bench input and
	// every registered output still holds its value from before the edge.
	// The result beat is checked before the request beat of the same edge is
	// modeled, since that result belongs to an earlier request.
	always @(posedge clk) begin
		deq_result_t owed;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result beat", pop_value, '0);
				end else begin
					owed = awaited_results.pop_front();
					if (pop_value !== owed.value)
						report_mismatch("pop_value", pop_value, owed.value);
					if (status !== owed.stat)
						report_mismatch("status", DATA_W'(status), DATA_W'(owed.stat));
					if (count !== owed.cnt)
						report_mismatch("count", DATA_W'(count), DATA_W'(owed.cnt));
					if (is_empty !== owed.empty)
						report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(owed.empty));
					if (is_full !== owed.full)
						report_mismatch("is_full", DATA_W'(is_full), DATA_W'(owed.full));
				end
				results_seen++;
				if (status == ST_OVERFLOW) overflows++;
				if (status == ST_UNDERFLOW) underflows++;
				if (is_full) full_results++;
			end
			if (in_valid && in_ready) begin
				owed = deque_apply(req_type, push_value);
				if (row_typed) begin
					owed = row_want;
				end
				awaited_results.push_back(owed);
				requests_seen++;
				if (req_type == REQ_PUSH_BACK || req_type == REQ_PUSH_FRONT) begin
					pushes_seen++;
				end else begin
					pops_seen++;
				end
			end
		end
	end

	// Receiver. It stalls at random by the current percentage, and on request
	// from the stimulus process it holds ready low for a long stretch that it
	// counts down itself.
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: the run is hung if neither side moves a beat for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles, %0d results still owed",
					quiet_cycles, awaited_results.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted. Idle
	// cycles, if any, come before the beat; valid stays high until accepted.
	task automatic offer_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] word,
		logic typed, deq_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		push_value <= word;
		row_typed  <= typed;
		row_want   <= want;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Mostly random words, with the extremes and the all-zero and all-one
	// patterns showing up often.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Biased walk: every 16 requests the mix leans toward pushes, toward pops
	// or sits even, so the queue keeps running into both full and empty.
	task automatic run_random_requests(int n);
		int               push_pct;
		logic [REQ_W-1:0] req;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0) begin
				case ($urandom_range(2))
					0:       push_pct = 80;
					1:       push_pct = 20;
					default: push_pct = 50;
				endcase
			end
			if ($urandom_range(99) < push_pct) begin
				req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			end else begin
				req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
			end
			offer_request(req, pick_word(), 1'b0, '0);
		end
	endtask

	// Takes valid down and waits until every owed result has come back.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Stimulus and end of run.
	initial begin
		model_head = 0;
		model_fill = 0;
		foreach (model_slots[i]) begin
			model_slots[i] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with both sides running flat out.
		foreach (DIRECTED_ROWS[i]) begin
			offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].word,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end
		wait_until_drained();

		// No idling on either side.
		run_random_requests(400);
		wait_until_drained();

		// Long receiver hold-off while the sender keeps offering: the output
		// register and read stage fill and in_ready has to drop.
		hold_requests++;
		run_random_requests(60);
		wait_until_drained();

		// Sender idle most of the time.
		send_idle_pct = 88;
		run_random_requests(300);
		wait_until_drained();

		// Receiver stalling most of the time.
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		run_random_requests(300);
		wait_until_drained();

		// Both sides idling now and then.
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		run_random_requests(500);
		wait_until_drained();

		// Let any stray beat surface while the receiver is always ready.
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d pushes, %0d pops) through five handshake phases.",
			requests_seen, pushes_seen, pops_seen);
		$display("Compared %0d results: %0d overflows, %0d underflows, %0d full, %0d bad fields.",
			results_seen, overflows, underflows, full_results, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_store.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue_unit.sv
verif/testbench.sv
